/* design/hjbp_pkg.sv */
// shared types and constants for the hash join build/probe engine
`default_nettype none
package hjbp_pkg;
    localparam int unsigned FIELD_WIDTH = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PROBE  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2
    } status_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_MATCH  = 1'b1;

    // strobes from the controller to the entry store
    typedef struct packed {
        logic we;
        logic re;
    } store_ctl_t;
endpackage
`default_nettype wire

/* design/hjbp_if.sv */
// valid/ready channel interfaces for input and result words
`default_nettype none
interface hjbp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] join_key;
    logic [63:0] payload;
    modport source (output valid, operation, join_key, payload, input ready);
    modport sink   (input valid, operation, join_key, payload, output ready);
endinterface

interface hjbp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [63:0] out_key;
    logic [63:0] left_payload;
    logic [63:0] right_payload;
    logic        last;
    modport source (output valid, kind, status, out_key, left_payload, right_payload,
                    last, input ready);
    modport sink   (input valid, kind, status, out_key, left_payload, right_payload,
                    last, output ready);
endinterface
`default_nettype wire

/* design/hjbp_store.sv */
// entry store: key and payload memory, one write and one registered read port
`default_nettype none
module hjbp_store #(
    parameter int unsigned TABLE_ENTRIES = 1024,
    parameter int unsigned KEY_WIDTH     = 64,
    parameter int unsigned PAYLOAD_WIDTH = 64,
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic                     clk,
    input  wire hjbp_pkg::store_ctl_t     ctl,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [KEY_WIDTH-1:0]     wkey,
    input  wire logic [PAYLOAD_WIDTH-1:0] wpay,
    input  wire logic [AW-1:0]            raddr,
    output logic [KEY_WIDTH-1:0]          rkey,
    output logic [PAYLOAD_WIDTH-1:0]      rpay
);
    import hjbp_pkg::*;

    logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0] mem [TABLE_ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= {wkey, wpay};
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            {rkey, rpay} <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* design/hash_join_build_probe.sv */
// top level of the hash join build/probe engine
//
// channel  dir  handshake      word
// in_ch    in   valid/ready    operation, join_key, payload
// out_ch   out  valid/ready    kind, status, out_key, left/right payload, last
//
// an insert below a full table or a probe scans every stored entry (read, compare)
// through the single read port of the entry store; clear and unused codes skip it
// results leave through one output register; a stalled output holds a probe scan
// at the compare step; reset clears the state, count, output valid and pending flag
`default_nettype none
module hash_join_build_probe #(
    parameter int unsigned TABLE_ENTRIES = 1024,
    parameter int unsigned MAX_MATCHES   = 64,
    parameter int unsigned KEY_WIDTH     = 64,
    parameter int unsigned PAYLOAD_WIDTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hjbp_in_if.sink     in_ch,
    hjbp_out_if.source  out_ch
);
    import hjbp_pkg::*;

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned DW = $clog2(MAX_MATCHES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
    localparam logic [DW-1:0] DUP_LIMIT  = DW'(MAX_MATCHES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_CMP   = 5'b00100,
        S_FLUSH = 5'b01000,
        S_STAT  = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [DW-1:0]            dup_reg, dup_next;
    logic                     probe_reg, probe_next;
    logic                     pend_reg, pend_next;
    logic [PAYLOAD_WIDTH-1:0] pend_pay_reg, pend_pay_next;
    logic [KEY_WIDTH-1:0]     key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;

    logic                     ov_reg, ov_next;
    logic                     o_kind_reg, o_kind_next;
    status_t                  o_stat_reg, o_stat_next;
    logic [KEY_WIDTH-1:0]     o_key_reg, o_key_next;
    logic [PAYLOAD_WIDTH-1:0] o_left_reg, o_left_next;
    logic [PAYLOAD_WIDTH-1:0] o_right_reg, o_right_next;
    logic                     o_last_reg, o_last_next;

    store_ctl_t               ctl;
    logic [KEY_WIDTH-1:0]     rkey;
    logic [PAYLOAD_WIDTH-1:0] rpay;
    logic                     slot_free, match, scan_end, accept;

    hjbp_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_store (
        .clk   (clk),
        .ctl   (ctl),
        .waddr (count_reg[AW-1:0]),
        .wkey  (key_reg),
        .wpay  (pay_reg),
        .raddr (idx_reg[AW-1:0]),
        .rkey  (rkey),
        .rpay  (rpay)
    );

    assign slot_free = !ov_reg || out_ch.ready;
    assign accept    = in_ch.valid && in_ch.ready;
    assign match     = (rkey == key_reg);
    assign scan_end  = (idx_reg + CW'(1)) == count_reg;

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = ov_reg;
    assign out_ch.kind          = o_kind_reg;
    assign out_ch.status        = o_stat_reg;
    assign out_ch.out_key       = FIELD_WIDTH'(o_key_reg);
    assign out_ch.left_payload  = FIELD_WIDTH'(o_left_reg);
    assign out_ch.right_payload = (o_kind_reg == KIND_MATCH) ? FIELD_WIDTH'(o_right_reg)
                                                              : '0;
    assign out_ch.last          = o_last_reg;

    // sequencer: scan, compare, emit
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        dup_next      = dup_reg;
        probe_next    = probe_reg;
        pend_next     = pend_reg;
        pend_pay_next = pend_pay_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        ov_next       = ov_reg && !out_ch.ready;
        o_kind_next   = o_kind_reg;
        o_stat_next   = o_stat_reg;
        o_key_next    = o_key_reg;
        o_left_next   = o_left_reg;
        o_right_next  = o_right_reg;
        o_last_next   = o_last_reg;
        ctl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next   = in_ch.join_key[KEY_WIDTH-1:0];
                    pay_next   = in_ch.payload[PAYLOAD_WIDTH-1:0];
                    idx_next   = '0;
                    dup_next   = '0;
                    pend_next  = 1'b0;
                    probe_next = (in_ch.operation == OP_PROBE);
                    case (in_ch.operation)
                        OP_INSERT:
                        begin
                            if (count_reg == '0 || count_reg == FULL_COUNT)
                                state_next = S_STAT;
                            else
                                state_next = S_RD;
                        end
                        OP_PROBE:
                        begin
                            if (count_reg != '0)
                                state_next = S_RD;
                        end
                        OP_CLEAR: count_next = '0;
                        default:  ;
                    endcase
                end
            end
            S_RD:
            begin
                ctl.re     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (probe_reg && match && pend_reg && !slot_free)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    if (match)
                    begin
                        if (probe_reg)
                        begin
                            if (pend_reg)
                            begin
                                ov_next      = 1'b1;
                                o_kind_next  = KIND_MATCH;
                                o_stat_next  = ST_OK;
                                o_key_next   = key_reg;
                                o_left_next  = pend_pay_reg;
                                o_right_next = pay_reg;
                                o_last_next  = 1'b0;
                            end
                            pend_next     = 1'b1;
                            pend_pay_next = rpay;
                        end
                        else if (dup_reg != DUP_LIMIT)
                        begin
                            dup_next = dup_reg + DW'(1);
                        end
                    end
                    idx_next = idx_reg + CW'(1);
                    if (scan_end)
                        state_next = probe_reg ? S_FLUSH : S_STAT;
                    else
                        state_next = S_RD;
                end
            end
            S_FLUSH:
            begin
                if (!pend_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    ov_next      = 1'b1;
                    o_kind_next  = KIND_MATCH;
                    o_stat_next  = ST_OK;
                    o_key_next   = key_reg;
                    o_left_next  = pend_pay_reg;
                    o_right_next = pay_reg;
                    o_last_next  = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_STAT:
            begin
                if (slot_free)
                begin
                    ov_next      = 1'b1;
                    o_kind_next  = KIND_STATUS;
                    o_key_next   = key_reg;
                    o_left_next  = pay_reg;
                    o_right_next = '0;
                    o_last_next  = 1'b1;
                    if (count_reg == FULL_COUNT)
                        o_stat_next = ST_FULL;
                    else if (dup_reg == DUP_LIMIT)
                        o_stat_next = ST_DUP;
                    else
                    begin
                        o_stat_next = ST_OK;
                        ctl.we      = 1'b1;
                        count_next  = count_reg + CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        dup_reg      <= dup_next;
        probe_reg    <= probe_next;
        pend_pay_reg <= pend_pay_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        o_kind_reg   <= o_kind_next;
        o_stat_reg   <= o_stat_next;
        o_key_reg    <= o_key_next;
        o_left_reg   <= o_left_next;
        o_right_reg  <= o_right_next;
        o_last_reg   <= o_last_next;
    end

    // the entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above table size");

    // a store write only happens below a full table
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.we |-> count_reg < FULL_COUNT)
        else $error("write into a full table");

    // no pending match is left behind once idle
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("pending match lost");

    // the scan index stays inside the stored entries while comparing
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> idx_reg < count_reg)
        else $error("scan index beyond entry count");
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// testbench for the hash join build/probe engine: directed and random words, scoreboard check
`default_nettype none
import hjbp_pkg::*;

typedef struct {
    logic        kind;
    status_t     status;
    logic [63:0] out_key;
    logic [63:0] left_payload;
    logic [63:0] right_payload;
    logic        last;
} join_word_t;

class join_scoreboard;
    logic [63:0] tbl_key [1024];
    logic [63:0] tbl_pay [1024];
    int unsigned tbl_count;
    join_word_t  pending [$];
    int unsigned mismatches;

    function new();
        tbl_count  = 0;
        mismatches = 0;
    endfunction

    // predict the results of one accepted input word
    function void note_input(op_t op, logic [63:0] key, logic [63:0] pay);
        join_word_t w;
        int unsigned dup;
        int unsigned hits;
        int          last_idx;
        dup = 0;
        hits = 0;
        w.status = ST_OK;
        w.right_payload = '0;
        w.out_key = key;
        case (op)
            OP_INSERT:
            begin
                if (tbl_count >= 1024) w.status = ST_FULL;
                else
                begin
                    for (int i = 0; i < tbl_count; i++)
                        if (tbl_key[i] == key) dup++;
                    if (dup >= 64) w.status = ST_DUP;
                    else
                    begin
                        tbl_key[tbl_count] = key;
                        tbl_pay[tbl_count] = pay;
                        tbl_count++;
                    end
                end
                w.kind = KIND_STATUS;
                w.left_payload = pay;
                w.last = 1'b1;
                pending.push_back(w);
            end
            OP_PROBE:
            begin
                last_idx = -1;
                for (int i = 0; i < tbl_count && hits < 64; i++)
                    if (tbl_key[i] == key)
                    begin
                        w.kind = KIND_MATCH;
                        w.left_payload = tbl_pay[i];
                        w.right_payload = pay;
                        w.last = 1'b0;
                        pending.push_back(w);
                        last_idx = pending.size() - 1;
                        hits++;
                    end
                if (last_idx >= 0) pending[last_idx].last = 1'b1;
            end
            OP_CLEAR: tbl_count = 0;
            default: ;
        endcase
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(join_word_t got);
        join_word_t exp;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result kind=%0d key=%h", got.kind, got.out_key);
            return;
        end
        exp = pending.pop_front();
        if (got.kind !== exp.kind || got.status !== exp.status || got.out_key !== exp.out_key ||
            got.left_payload !== exp.left_payload ||
            got.right_payload !== exp.right_payload || got.last !== exp.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp k%0d s%0d %h %h %h l%0d got k%0d s%0d %h %h %h l%0d",
                    exp.kind, exp.status, exp.out_key, exp.left_payload, exp.right_payload,
                    exp.last, got.kind, got.status, got.out_key, got.left_payload,
                    got.right_payload, got.last);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    hjbp_in_if  in_ch ();
    hjbp_out_if out_ch ();
    join_scoreboard board;
    int unsigned idle_cycles = 0;
    logic [63:0] key_pool [8];

    hash_join_build_probe dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // send one word, with a random gap before it; returns at the accepting edge
    task automatic send_word(op_t op, logic [63:0] key, logic [63:0] pay);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.join_key  <= key;
        in_ch.payload   <= pay;
        @(posedge clk iff in_ch.ready);
        board.note_input(op, key, pay);
    endtask

    // drop valid after the last word of a burst
    task automatic idle_input();
        in_ch.valid <= 1'b0;
    endtask

    // result sink with random stalls
    initial
    begin
        join_word_t got;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        out_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk iff (out_ch.valid && out_ch.ready));
            got.kind = out_ch.kind;
            got.status = status_t'(out_ch.status);
            got.out_key = out_ch.out_key;
            got.left_payload = out_ch.left_payload;
            got.right_payload = out_ch.right_payload;
            got.last = out_ch.last;
            board.check_result(got);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        op_t op;
        int unsigned r;
        logic [63:0] key;
        board = new();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.join_key = '0;
        in_ch.payload = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every code, duplicate limit
        send_word(OP_PROBE, '0, '1);
        send_word(OP_INSERT, '0, '0);
        send_word(OP_INSERT, '1, '1);
        send_word(OP_INSERT, '1, 64'h5555_aaaa_0f0f_f0f0);
        send_word(OP_PROBE, '1, '0);
        send_word(OP_PROBE, '0, 64'haaaa_5555_f0f0_0f0f);
        send_word(OP_NONE, '1, '1);
        send_word(OP_PROBE, 64'h1, '0);
        send_word(OP_CLEAR, '0, '0);
        send_word(OP_PROBE, '1, '1);
        for (int i = 0; i < 66; i++)
            send_word(OP_INSERT, 64'hdead_beef, 64'(i));
        send_word(OP_PROBE, 64'hdead_beef, 64'h1234);
        send_word(OP_CLEAR, '0, '0);
        idle_input();

        // hold off until every prediction has been checked
        while (board.pending.size() != 0) @(posedge clk);

        // random: keys from a small pool so probes hit
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < 320; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50) op = OP_INSERT;
            else if (r < 92) op = OP_PROBE;
            else if (r < 96) op = OP_CLEAR;
            else op = OP_NONE;
            key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(0, 7)];
            send_word(op, key, {$urandom, $urandom});
        end
        idle_input();

        while (board.pending.size() != 0) @(posedge clk);
        repeat (2100) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
